/* sv/mlca_pkg.sv */
// Shared types and constants for the masked local color adjust block.
// Holds the configuration record, register indexes, blend modes and fixed-point widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mlca_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ALPHA_W    = 13;
  localparam int FRAC_BITS  = 12;
  localparam int ONE_Q12    = 4096;
  localparam int HALF_Q12   = 2048;
  localparam int NUM_LAYERS = 8;
  localparam int NUM_MASKS  = NUM_LAYERS + 1;
  localparam int NUM_STAGES = 11;
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 48;
  localparam int ADJ_W      = 27;
  localparam int ADJ2_W     = 34;
  localparam int WEIGHT_W   = 13;
  localparam int WPROD_W    = ADJ_W + WEIGHT_W;

  localparam logic signed [WEIGHT_W-1:0] LUMA_W [3] = '{13'sd871, 13'sd2929, 13'sd296};

  typedef enum logic [2:0] {
    REG_LAYER_COUNT       = 3'd0,
    REG_LAYER_ENABLE      = 3'd1,
    REG_LAYER_INVERT      = 3'd2,
    REG_LAYER_BLEND       = 3'd3,
    REG_EXTRA_MASK_CTRL   = 3'd4,
    REG_EXPOSURE_GAIN     = 3'd5,
    REG_CONTRAST_FACTOR   = 3'd6,
    REG_SATURATION_FACTOR = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BLEND_OVER   = 2'd0,
    BLEND_MUL    = 2'd1,
    BLEND_SCREEN = 2'd2,
    BLEND_NORMAL = 2'd3
  } blend_e;

  typedef struct packed {
    logic [3:0]  layer_count;
    logic [7:0]  layer_enable;
    logic [7:0]  layer_invert;
    logic [15:0] layer_blend;
    logic [2:0]  extra_mask_ctrl;
    logic [15:0] exposure_gain;
    logic [15:0] contrast_factor;
    logic [15:0] saturation_factor;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    layer_count:       4'd0,
    layer_enable:      8'd0,
    layer_invert:      8'd0,
    layer_blend:       16'd0,
    extra_mask_ctrl:   3'd0,
    exposure_gain:     16'd4096,
    contrast_factor:   16'd4096,
    saturation_factor: 16'd4096
  };

  typedef struct packed {
    logic               have;
    logic [ALPHA_W-1:0] alpha;
  } fold_t;

endpackage

`default_nettype wire

/* sv/mlca_fold_stage.sv */
// One mask layer of the alpha fold: clamp, invert, blend into the running alpha.
// Uses mlca_pkg for the fold record and blend modes.
`timescale 1ns / 1ps
`default_nettype none

module mlca_fold_stage (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  mlca_pkg::fold_t               fold_i,
  input  logic [mlca_pkg::ALPHA_W-1:0]  raw_alpha_i,
  input  logic                          layer_on_i,
  input  logic                          invert_i,
  input  mlca_pkg::blend_e              mode_i,
  output mlca_pkg::fold_t               fold_o
);
  import mlca_pkg::*;

  logic [ALPHA_W-1:0]   clamped;
  logic [ALPHA_W-1:0]   layer_alpha;
  logic [ALPHA_W-1:0]   op_x;
  logic [ALPHA_W-1:0]   op_y;
  logic [2*ALPHA_W-1:0] prod;
  logic [2*ALPHA_W-1:0] prod_rnd;
  logic [ALPHA_W-1:0]   scaled;
  logic [ALPHA_W-1:0]   merged;
  fold_t                fold_d;
  fold_t                fold_q;

  always_comb begin
    clamped     = (raw_alpha_i > ALPHA_W'(ONE_Q12)) ? ALPHA_W'(ONE_Q12) : raw_alpha_i;
    layer_alpha = invert_i ? ALPHA_W'(ONE_Q12) - clamped : clamped;
    case (mode_i)
      BLEND_MUL: begin
        op_x = fold_i.alpha;
        op_y = layer_alpha;
      end
      BLEND_SCREEN: begin
        op_x = ALPHA_W'(ONE_Q12) - fold_i.alpha;
        op_y = ALPHA_W'(ONE_Q12) - layer_alpha;
      end
      default: begin
        op_x = layer_alpha;
        op_y = ALPHA_W'(ONE_Q12) - fold_i.alpha;
      end
    endcase
    prod     = op_x * op_y;
    prod_rnd = prod + (2*ALPHA_W)'(HALF_Q12);
    scaled   = prod_rnd[FRAC_BITS +: ALPHA_W];
    case (mode_i)
      BLEND_MUL:    merged = scaled;
      BLEND_SCREEN: merged = ALPHA_W'(ONE_Q12) - scaled;
      default:      merged = fold_i.alpha + scaled;
    endcase
    if (!layer_on_i) begin
      fold_d = fold_i;
    end else if (!fold_i.have) begin
      fold_d = '{have: 1'b1, alpha: layer_alpha};
    end else begin
      fold_d = '{have: 1'b1, alpha: merged};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_q <= fold_d;
    end
  end

  assign fold_o = fold_q;

endmodule

`default_nettype wire

/* sv/mlca_lane_front.sv */
// Color lane front half: exposure gain, contrast about one half, luma weight product.
// Uses mlca_pkg for widths and rounding constants.
`timescale 1ns / 1ps
`default_nettype none

module mlca_lane_front (
  input  logic                                   clk_i,
  input  logic [3:1]                             en_i,
  input  logic [mlca_pkg::SAMPLE_W-1:0]          px_i,
  input  logic [15:0]                            gain_i,
  input  logic [15:0]                            contrast_i,
  input  logic signed [mlca_pkg::WEIGHT_W-1:0]   weight_i,
  output logic [mlca_pkg::SAMPLE_W-1:0]          px_o,
  output logic signed [mlca_pkg::ADJ_W-1:0]      adj_o,
  output logic signed [mlca_pkg::WPROD_W-1:0]    wprod_o
);
  import mlca_pkg::*;

  logic [SAMPLE_W-1:0]       px1_q, px2_q, px3_q;
  logic [31:0]               pe_q;
  logic [32:0]               pe_rnd;
  logic [20:0]               expo;
  logic signed [21:0]        centered;
  logic signed [38:0]        pc_d, pc_q;
  logic signed [38:0]        pc_rnd;
  logic signed [ADJ_W-1:0]   adj_d, adj_q;
  logic signed [WPROD_W-1:0] wp_d, wp_q;

  always_comb begin
    pe_rnd   = {1'b0, pe_q} + 33'(HALF_Q12);
    expo     = pe_rnd[32:FRAC_BITS];
    centered = $signed({1'b0, expo}) - $signed(22'(HALF_Q12));
    pc_d     = centered * $signed({1'b0, contrast_i});
    pc_rnd   = pc_q + $signed(39'(HALF_Q12));
    adj_d    = $signed(ADJ_W'(HALF_Q12)) + ADJ_W'(pc_rnd >>> FRAC_BITS);
    wp_d     = adj_d * weight_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      px1_q <= px_i;
      pe_q  <= px_i * gain_i;
    end
    if (en_i[2]) begin
      px2_q <= px1_q;
      pc_q  <= pc_d;
    end
    if (en_i[3]) begin
      px3_q <= px2_q;
      adj_q <= adj_d;
      wp_q  <= wp_d;
    end
  end

  assign px_o    = px3_q;
  assign adj_o   = adj_q;
  assign wprod_o = wp_q;

endmodule

`default_nettype wire

/* sv/mlca_luma_merge.sv */
// Merge of the three color lanes: sums weighted samples into Rec.709 luma.
// Uses mlca_pkg for widths and rounding constants.
`timescale 1ns / 1ps
`default_nettype none

module mlca_luma_merge (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [mlca_pkg::WPROD_W-1:0]  wprod_r_i,
  input  logic signed [mlca_pkg::WPROD_W-1:0]  wprod_g_i,
  input  logic signed [mlca_pkg::WPROD_W-1:0]  wprod_b_i,
  output logic signed [mlca_pkg::ADJ_W-1:0]    luma_o
);
  import mlca_pkg::*;

  logic signed [WPROD_W+1:0] sum;
  logic signed [ADJ_W-1:0]   luma_q;

  assign sum = (WPROD_W+2)'(wprod_r_i) + (WPROD_W+2)'(wprod_g_i)
             + (WPROD_W+2)'(wprod_b_i) + $signed((WPROD_W+2)'(HALF_Q12));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      luma_q <= ADJ_W'(sum >>> FRAC_BITS);
    end
  end

  assign luma_o = luma_q;

endmodule

`default_nettype wire

/* sv/mlca_lane_back.sv */
// Color lane back half: saturation about luma, alpha mix with the original, clamp.
// Uses mlca_pkg for widths, the fold record and rounding constants.
`timescale 1ns / 1ps
`default_nettype none

module mlca_lane_back (
  input  logic                                clk_i,
  input  logic [mlca_pkg::NUM_STAGES:4]       en_i,
  input  logic [mlca_pkg::SAMPLE_W-1:0]       px_i,
  input  logic signed [mlca_pkg::ADJ_W-1:0]   adj_i,
  input  logic signed [mlca_pkg::ADJ_W-1:0]   luma_i,
  input  logic [15:0]                         sat_i,
  input  mlca_pkg::fold_t                     fold_i,
  output logic [mlca_pkg::SAMPLE_W-1:0]       sample_o
);
  import mlca_pkg::*;

  logic [SAMPLE_W-1:0]      px_q [4:10];
  logic signed [ADJ_W-1:0]  adj4_q;
  logic signed [ADJ_W-1:0]  luma5_q;
  logic signed [ADJ_W:0]    diff;
  logic signed [44:0]       ps_d, ps_q;
  logic signed [44:0]       ps_rnd;
  logic signed [ADJ2_W-1:0] adj2_d;
  logic signed [ADJ2_W-1:0] adj2_q [6:9];
  logic [ALPHA_W-1:0]       alpha_inv;
  logic [28:0]              po_q;
  logic signed [47:0]       pa_q;
  logic                     have10_q;
  logic signed [48:0]       mix_sum;
  logic signed [36:0]       mix_val;
  logic [SAMPLE_W-1:0]      mix_sat;
  logic [SAMPLE_W-1:0]      out_q;

  always_comb begin
    diff      = (ADJ_W+1)'(adj4_q) - (ADJ_W+1)'(luma_i);
    ps_d      = diff * $signed({1'b0, sat_i});
    ps_rnd    = ps_q + $signed(45'(HALF_Q12));
    adj2_d    = ADJ2_W'(luma5_q) + ADJ2_W'(ps_rnd >>> FRAC_BITS);
    alpha_inv = ALPHA_W'(ONE_Q12) - fold_i.alpha;
    mix_sum   = $signed({20'd0, po_q}) + 49'(pa_q) + $signed(49'(HALF_Q12));
    mix_val   = 37'(mix_sum >>> FRAC_BITS);
    if (mix_val[36]) begin
      mix_sat = '0;
    end else if (|mix_val[35:SAMPLE_W]) begin
      mix_sat = '1;
    end else begin
      mix_sat = mix_val[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      px_q[4] <= px_i;
      adj4_q  <= adj_i;
    end
    if (en_i[5]) begin
      px_q[5] <= px_q[4];
      ps_q    <= ps_d;
      luma5_q <= luma_i;
    end
    if (en_i[6]) begin
      px_q[6]   <= px_q[5];
      adj2_q[6] <= adj2_d;
    end
    for (int s = 7; s <= 9; s++) begin
      if (en_i[s]) begin
        px_q[s]   <= px_q[s-1];
        adj2_q[s] <= adj2_q[s-1];
      end
    end
    if (en_i[10]) begin
      px_q[10] <= px_q[9];
      po_q     <= px_q[9] * alpha_inv;
      pa_q     <= adj2_q[9] * $signed({1'b0, fold_i.alpha});
      have10_q <= fold_i.have;
    end
    if (en_i[11]) begin
      out_q <= have10_q ? mix_sat : px_q[10];
    end
  end

  assign sample_o = out_q;

endmodule

`default_nettype wire

/* sv/masked_local_color_adjust.sv */
// Throughput: one word per cycle unless the output stalls; each stage holds an item and
// moves on when the next is free; in an output stall input is taken while a stage is empty.
// The nine serial alpha fold stages (one Q1.12 multiply each) set the depth.
// Reset clears the stage valid bits and loads the register reset values; data is not reset.
// Top level: config registers, pipeline control, mask delay line, fold chain, color lanes.
`timescale 1ns / 1ps
`default_nettype none

module masked_local_color_adjust (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_idx_i,
  input  logic [15:0]                          cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // red_in, green_in, blue_in, mask_alpha_0..mask_alpha_7, extra_alpha, zero pad
  input  logic [mlca_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // red_out, green_out, blue_out
  output logic [mlca_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import mlca_pkg::*;

  cfg_t                       cfg_q;
  logic [NUM_STAGES:1]        valid_q;
  logic [NUM_STAGES:1]        en;
  logic [SAMPLE_W-1:0]        in_px [3];
  logic [ALPHA_W-1:0]         in_mask [NUM_MASKS];
  logic [ALPHA_W-1:0]         mask_q [1:NUM_LAYERS][NUM_MASKS];
  fold_t                      fold_w [NUM_MASKS+1];
  logic [SAMPLE_W-1:0]        px3 [3];
  logic signed [ADJ_W-1:0]    adj3 [3];
  logic signed [WPROD_W-1:0]  wprod3 [3];
  logic signed [ADJ_W-1:0]    luma4;
  logic [SAMPLE_W-1:0]        sample [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LAYER_COUNT:       cfg_q.layer_count       <= cfg_data_i[3:0];
        REG_LAYER_ENABLE:      cfg_q.layer_enable      <= cfg_data_i[7:0];
        REG_LAYER_INVERT:      cfg_q.layer_invert      <= cfg_data_i[7:0];
        REG_LAYER_BLEND:       cfg_q.layer_blend       <= cfg_data_i;
        REG_EXTRA_MASK_CTRL:   cfg_q.extra_mask_ctrl   <= cfg_data_i[2:0];
        REG_EXPOSURE_GAIN:     cfg_q.exposure_gain     <= cfg_data_i;
        REG_CONTRAST_FACTOR:   cfg_q.contrast_factor   <= cfg_data_i;
        REG_SATURATION_FACTOR: cfg_q.saturation_factor <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NUM_STAGES] = ~valid_q[NUM_STAGES] | m_axis_tready;
    for (int s = NUM_STAGES - 1; s >= 1; s--) begin
      en[s] = ~valid_q[s] | en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) begin
        valid_q[1] <= s_axis_tvalid;
      end
      for (int s = 2; s <= NUM_STAGES; s++) begin
        if (en[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = valid_q[NUM_STAGES];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      in_px[c] = s_axis_tdata[c*SAMPLE_W +: SAMPLE_W];
    end
    for (int k = 0; k < NUM_MASKS; k++) begin
      in_mask[k] = s_axis_tdata[3*SAMPLE_W + k*ALPHA_W +: ALPHA_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mask_q[1] <= in_mask;
    end
    for (int s = 2; s <= NUM_LAYERS; s++) begin
      if (en[s]) begin
        mask_q[s] <= mask_q[s-1];
      end
    end
  end

  assign fold_w[0] = '{have: 1'b0, alpha: '0};

  for (genvar k = 0; k < NUM_MASKS; k++) begin : g_fold
    logic [ALPHA_W-1:0] raw;
    logic               layer_on;
    logic               invert;
    blend_e             mode;

    if (k == 0) begin : g_first
      assign raw = in_mask[0];
    end else begin : g_delayed
      assign raw = mask_q[k][k];
    end

    if (k < NUM_LAYERS) begin : g_layer
      assign layer_on = cfg_q.layer_enable[k] && (cfg_q.layer_count > 4'(k));
      assign invert   = cfg_q.layer_invert[k];
      assign mode     = blend_e'(cfg_q.layer_blend[2*k +: 2]);
    end else begin : g_extra
      assign layer_on = cfg_q.extra_mask_ctrl[0] && (cfg_q.layer_count != 4'd0);
      assign invert   = 1'b0;
      assign mode     = blend_e'(cfg_q.extra_mask_ctrl[2:1]);
    end

    mlca_fold_stage u_stage (
      .clk_i       (clk_i),
      .en_i        (en[k+1]),
      .fold_i      (fold_w[k]),
      .raw_alpha_i (raw),
      .layer_on_i  (layer_on),
      .invert_i    (invert),
      .mode_i      (mode),
      .fold_o      (fold_w[k+1])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_front
    mlca_lane_front u_front (
      .clk_i      (clk_i),
      .en_i       (en[3:1]),
      .px_i       (in_px[c]),
      .gain_i     (cfg_q.exposure_gain),
      .contrast_i (cfg_q.contrast_factor),
      .weight_i   (LUMA_W[c]),
      .px_o       (px3[c]),
      .adj_o      (adj3[c]),
      .wprod_o    (wprod3[c])
    );
  end

  mlca_luma_merge u_merge (
    .clk_i     (clk_i),
    .en_i      (en[4]),
    .wprod_r_i (wprod3[0]),
    .wprod_g_i (wprod3[1]),
    .wprod_b_i (wprod3[2]),
    .luma_o    (luma4)
  );

  for (genvar c = 0; c < 3; c++) begin : g_back
    mlca_lane_back u_back (
      .clk_i    (clk_i),
      .en_i     (en[NUM_STAGES:4]),
      .px_i     (px3[c]),
      .adj_i    (adj3[c]),
      .luma_i   (luma4),
      .sat_i    (cfg_q.saturation_factor),
      .fold_i   (fold_w[NUM_MASKS]),
      .sample_o (sample[c])
    );
  end

  assign m_axis_tdata = {sample[2], sample[1], sample[0]};

endmodule

`default_nettype wire
